[rtl/core/bal_pkg.sv]
// ----------------------------------------------------------------------------
// bal_pkg: bounded array list shared types
// Operation and status codes, cell actions and the command broadcast to cells.
// ----------------------------------------------------------------------------
package bal_pkg;

	// wide enough for an index or a count up to the largest capacity (256)
	localparam int IDX_W = 9;

	typedef enum logic [2:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_BACK   = 3'd2,
		OP_POP_FRONT  = 3'd3,
		OP_INSERT     = 3'd4,
		OP_SEARCH     = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_BAD_INDEX = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ACT_HOLD,
		ACT_PLACE,
		ACT_POP_FRONT
	} act_t;

	typedef struct packed {
		act_t             act;
		logic [IDX_W-1:0] pos;
		logic [IDX_W-1:0] cnt;
	} cell_cmd_t;

endpackage

[rtl/core/bal_cell.sv]
// ----------------------------------------------------------------------------
// bal_cell: one list slot
// Holds one entry; loads the new word, takes its lower or upper neighbor,
// or holds, and flags a match against the search word.
// ----------------------------------------------------------------------------
module bal_cell #(
	parameter int IDX        = 0,
	parameter int VALUE_BITS = 32
) (
	input  logic                    clk,
	input  bal_pkg::cell_cmd_t      cmd,
	input  logic [VALUE_BITS-1:0]   word,
	input  logic [VALUE_BITS-1:0]   lower_d,
	input  logic [VALUE_BITS-1:0]   upper_d,
	output logic [VALUE_BITS-1:0]   data_q,
	output logic                    match
);

	localparam logic [bal_pkg::IDX_W-1:0] MY_IDX  = bal_pkg::IDX_W'(IDX);
	localparam logic [bal_pkg::IDX_W-1:0] NXT_IDX = bal_pkg::IDX_W'(IDX + 1);

	always_ff @(posedge clk) begin
		unique case (cmd.act)
			bal_pkg::ACT_PLACE: begin
				if (MY_IDX == cmd.pos) begin
					data_q <= word;
				end else if (MY_IDX > cmd.pos && MY_IDX <= cmd.cnt) begin
					data_q <= lower_d;
				end
			end
			bal_pkg::ACT_POP_FRONT: begin
				if (NXT_IDX < cmd.cnt) begin
					data_q <= upper_d;
				end
			end
			default: begin
			end
		endcase
	end

	assign match = (MY_IDX < cmd.cnt) && (data_q == word);

endmodule

[rtl/core/bounded_array_list_top.sv]
// ----------------------------------------------------------------------------
// bounded_array_list_top: fixed-capacity ordered list of signed values
// Each transfer carries one operation (push front/back, pop back/front,
// insert at index, search) and returns one result the cycle after it is
// taken: status, found flag, entry count and full/empty flags. A new
// operation may start every cycle, since all slots sit in a row of cells
// that shift, load and compare in parallel; busy is never raised.
// Results appear for one cycle with done high and must be taken then.
// ----------------------------------------------------------------------------
module bounded_array_list_top #(
	parameter int CAPACITY   = 8,
	parameter int VALUE_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         op,
	input  logic signed [31:0] value,
	input  logic [3:0]         position,
	output logic               done,
	output logic [1:0]         status,
	output logic               found,
	output logic [3:0]         count,
	output logic               is_full,
	output logic               is_empty
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [bal_pkg::IDX_W-1:0] CAP_X = bal_pkg::IDX_W'(CAPACITY);
	localparam logic [bal_pkg::IDX_W-1:0] ONE_X = bal_pkg::IDX_W'(1);

	logic [CW-1:0]                cnt_q;
	logic [bal_pkg::IDX_W-1:0]    cnt_x;
	logic [bal_pkg::IDX_W-1:0]    cnt_n;
	logic [bal_pkg::IDX_W-1:0]    pos_x;
	logic [63:0]                  value_ext;
	logic [VALUE_BITS-1:0]        word;
	logic                         full;
	bal_pkg::cell_cmd_t           cmd;
	bal_pkg::status_t             status_n;
	logic                         found_n;
	logic                         take;
	logic [VALUE_BITS-1:0]        data [CAPACITY];
	logic [CAPACITY-1:0]          match;

	logic                         done_q;
	logic [1:0]                   status_q;
	logic                         found_q;
	logic [3:0]                   count_q;
	logic                         is_full_q;
	logic                         is_empty_q;

	assign busy      = 1'b0;
	assign take      = start && !busy;
	assign value_ext = {{32{value[31]}}, value};
	assign word      = value_ext[VALUE_BITS-1:0];
	assign cnt_x     = bal_pkg::IDX_W'(cnt_q);
	assign pos_x     = bal_pkg::IDX_W'(position);
	assign full      = (cnt_x == CAP_X);

	always_comb begin
		status_n = bal_pkg::ST_OK;
		found_n  = 1'b0;
		cnt_n    = cnt_x;
		cmd.act  = bal_pkg::ACT_HOLD;
		cmd.pos  = cnt_x;
		cmd.cnt  = cnt_x;
		unique case (bal_pkg::op_t'(op))
			bal_pkg::OP_PUSH_FRONT, bal_pkg::OP_PUSH_BACK: begin
				if (full) begin
					status_n = bal_pkg::ST_FULL;
				end else begin
					cmd.act = bal_pkg::ACT_PLACE;
					cmd.pos = (bal_pkg::op_t'(op) == bal_pkg::OP_PUSH_FRONT) ? '0 : cnt_x;
					cnt_n   = cnt_x + ONE_X;
				end
			end
			bal_pkg::OP_INSERT: begin
				if (full) begin
					status_n = bal_pkg::ST_FULL;
				end else if (pos_x > cnt_x) begin
					status_n = bal_pkg::ST_BAD_INDEX;
				end else begin
					cmd.act = bal_pkg::ACT_PLACE;
					cmd.pos = pos_x;
					cnt_n   = cnt_x + ONE_X;
				end
			end
			bal_pkg::OP_POP_BACK, bal_pkg::OP_POP_FRONT: begin
				if (cnt_x == '0) begin
					status_n = bal_pkg::ST_EMPTY;
				end else begin
					if (bal_pkg::op_t'(op) == bal_pkg::OP_POP_FRONT) begin
						cmd.act = bal_pkg::ACT_POP_FRONT;
					end
					cnt_n = cnt_x - ONE_X;
				end
			end
			bal_pkg::OP_SEARCH: begin
				found_n = |match;
			end
			default: begin
			end
		endcase
		if (!take) begin
			cmd.act = bal_pkg::ACT_HOLD;
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [VALUE_BITS-1:0] lower_d;
		logic [VALUE_BITS-1:0] upper_d;
		if (i == 0) begin : g_first
			assign lower_d = word;
		end else begin : g_lower
			assign lower_d = data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign upper_d = word;
		end else begin : g_upper
			assign upper_d = data[i+1];
		end
		bal_cell #(
			.IDX        (i),
			.VALUE_BITS (VALUE_BITS)
		) u_cell (
			.clk     (clk),
			.cmd     (cmd),
			.word    (word),
			.lower_d (lower_d),
			.upper_d (upper_d),
			.data_q  (data[i]),
			.match   (match[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= take;
			if (take) begin
				cnt_q <= cnt_n[CW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			status_q   <= status_n;
			found_q    <= found_n;
			count_q    <= cnt_n[3:0];
			is_full_q  <= (cnt_n == CAP_X);
			is_empty_q <= (cnt_n == '0);
		end
	end

	assign done     = done_q;
	assign status   = status_q;
	assign found    = found_q;
	assign count    = count_q;
	assign is_full  = is_full_q;
	assign is_empty = is_empty_q;

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> done)
		else $error("result transfer missing after start");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bal_pkg::IDX_W'(cnt_q) <= CAP_X)
		else $error("entry count above capacity");

	a_full_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == 2'(bal_pkg::ST_FULL) |-> is_full)
		else $error("full status without full flag");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == 2'(bal_pkg::ST_EMPTY) |-> is_empty)
		else $error("empty status without empty flag");

	a_found_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		done && found |-> !is_empty && status == 2'(bal_pkg::ST_OK))
		else $error("found on empty list");

endmodule
